### sv/khash_pkg.sv
`timescale 1ns / 1ps

package khash_pkg;

    // field widths fixed by the item formats
    localparam int KEY_W       = 64;
    localparam int KEY_BYTES   = KEY_W / 8;
    localparam int LEN_W       = 8;
    localparam int KIND_W      = 8;
    localparam int SLOT_W      = 6;
    localparam int SHIFT_W     = 6;
    localparam int COUNT_W     = 8;
    localparam int CFG_INDEX_W = 1;

    // longest word that forms a key
    localparam int MAX_KEY_BYTES = 8;

    // default table depth
    localparam int TABLE_SIZE_DEF = 26;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_HASH_MULTIPLIER = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRODUCT_SHIFT   = 1'd1;

    // configuration reset values
    localparam logic [KEY_W-1:0]   HASH_MULTIPLIER_RST = 64'd359426152;
    localparam logic [SHIFT_W-1:0] PRODUCT_SHIFT_RST   = 6'd31;

    // action codes
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    // incoming word
    typedef struct packed {
        logic              action;
        logic [KEY_W-1:0]  text_bytes;
        logic [LEN_W-1:0]  text_length;
        logic [KIND_W-1:0] kind_in;
    } item_t;

    // outgoing result
    typedef struct packed {
        logic               found;
        logic [KIND_W-1:0]  kind_out;
        logic [SLOT_W-1:0]  slot_index;
        logic               collided;
        logic [COUNT_W-1:0] collision_total;
    } result_t;

    // classified word handed from front to back
    typedef struct packed {
        logic              action;
        logic              key_valid;
        logic [KEY_W-1:0]  key;
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
    } job_t;

    // configuration registers
    typedef struct packed {
        logic [KEY_W-1:0]   hash_multiplier;
        logic [SHIFT_W-1:0] product_shift;
    } cfg_t;

endpackage

### sv/khash_front.sv
`timescale 1ns / 1ps

module khash_front #(
    parameter int TABLE_SIZE = khash_pkg::TABLE_SIZE_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  khash_pkg::item_t item,
    input  khash_pkg::cfg_t  cfg,
    output logic             job_push,
    input  logic             job_full,
    output khash_pkg::job_t  job
);
    import khash_pkg::*;

    localparam int RW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int XW = RW + 8;
    localparam logic [XW-1:0] MOD_N = XW'(TABLE_SIZE);
    localparam int HALF_W = KEY_W / 2;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_SUM,
        F_SHIFT,
        F_REDUCE,
        F_PUSH
    } front_state_t;

    front_state_t        state_reg;
    logic                action_reg;
    logic                key_valid_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [KEY_W-1:0]    pp_ll_reg;
    logic [HALF_W-1:0]   pp_hl_reg;
    logic [HALF_W-1:0]   pp_lh_reg;
    logic [KEY_W-1:0]    product_reg;
    logic [RW-1:0]       rem_reg;
    logic [2:0]          byte_cnt_reg;

    logic [KEY_W-1:0]    key_next;
    logic                len_ok;
    logic [RW-1:0]       rem_next;
    logic [2:0]          byte_sel;
    logic [HALF_W-1:0]   cross_sum;

    // big-endian packing of the word bytes
    always_comb
    begin
        logic [2:0] src;
        key_next = '0;
        src      = '0;
        for (int j = 0; j < KEY_BYTES; j++)
        begin
            src = 3'(item.text_length - 8'd1 - 8'(j));
            if (LEN_W'(j) < item.text_length)
            begin
                key_next[8*j +: 8] = item.text_bytes[8*src +: 8];
            end
        end
    end

    assign len_ok = (item.text_length >= LEN_W'(1)) &&
                    (item.text_length <= LEN_W'(MAX_KEY_BYTES));

    // one byte of the modulo reduction, most significant byte first
    assign byte_sel = 3'd7 - byte_cnt_reg;

    always_comb
    begin
        logic [XW-1:0] x;
        x = {rem_reg, product_reg[8*byte_sel +: 8]};
        for (int k = 7; k >= 0; k--)
        begin
            if (x >= (MOD_N << k))
            begin
                x = x - (MOD_N << k);
            end
        end
        rem_next = x[RW-1:0];
    end

    assign cross_sum = pp_hl_reg + pp_lh_reg;

    // sequencer: accept, multiply, add, shift, reduce, hand off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (push)
                    begin
                        action_reg    <= item.action;
                        kind_reg      <= item.kind_in;
                        key_reg       <= key_next;
                        key_valid_reg <= len_ok;
                        rem_reg       <= '0;
                        state_reg     <= len_ok ? F_MUL : F_PUSH;
                    end
                end
                F_MUL:
                begin
                    pp_ll_reg <= key_reg[HALF_W-1:0] * cfg.hash_multiplier[HALF_W-1:0];
                    pp_hl_reg <= HALF_W'(key_reg[KEY_W-1:HALF_W] *
                                         cfg.hash_multiplier[HALF_W-1:0]);
                    pp_lh_reg <= HALF_W'(key_reg[HALF_W-1:0] *
                                         cfg.hash_multiplier[KEY_W-1:HALF_W]);
                    state_reg <= F_SUM;
                end
                F_SUM:
                begin
                    product_reg <= pp_ll_reg + {cross_sum, {HALF_W{1'b0}}};
                    state_reg   <= F_SHIFT;
                end
                F_SHIFT:
                begin
                    product_reg  <= product_reg >> cfg.product_shift;
                    rem_reg      <= '0;
                    byte_cnt_reg <= '0;
                    state_reg    <= F_REDUCE;
                end
                F_REDUCE:
                begin
                    rem_reg      <= rem_next;
                    byte_cnt_reg <= byte_cnt_reg + 3'd1;
                    if (byte_cnt_reg == 3'd7)
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!job_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    // handshakes and handoff payload
    assign full     = (state_reg != F_IDLE);
    assign job_push = (state_reg == F_PUSH) && !job_full;

    always_comb
    begin
        job.action    = action_reg;
        job.key_valid = key_valid_reg;
        job.key       = key_reg;
        job.kind      = kind_reg;
        job.slot      = SLOT_W'(rem_reg);
    end

endmodule

### sv/khash_queue.sv
`timescale 1ns / 1ps

module khash_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  khash_pkg::job_t wr_job,
    input  logic            pop,
    output logic            empty,
    output khash_pkg::job_t rd_job
);
    import khash_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_job  = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### sv/khash_back.sv
`timescale 1ns / 1ps

module khash_back #(
    parameter int TABLE_SIZE = khash_pkg::TABLE_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_empty,
    output logic               job_pop,
    input  khash_pkg::job_t    job,
    output logic               empty,
    input  logic               pop,
    output khash_pkg::result_t result
);
    import khash_pkg::*;

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int ENT_W = KEY_W + KIND_W;

    typedef enum logic {
        B_IDLE,
        B_RESOLVE
    } back_state_t;

    back_state_t          state_reg;
    job_t                 cur_reg;
    logic [ENT_W-1:0]     rd_data_reg;
    logic [TABLE_SIZE-1:0] used_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 out_valid_reg;
    result_t              result_reg;

    logic [ENT_W-1:0]     slot_mem [TABLE_SIZE];

    logic [IDX_W-1:0]     rd_idx;
    logic [IDX_W-1:0]     cur_idx;
    logic                 slot_used;
    logic                 do_insert;
    logic                 collide;
    logic                 hit;
    logic [COUNT_W-1:0]   count_next;
    result_t              result_next;

    assign rd_idx  = job.slot[IDX_W-1:0];
    assign cur_idx = cur_reg.slot[IDX_W-1:0];

    // take a job only when the result register is free or being drained
    assign job_pop = (state_reg == B_IDLE) && !job_empty && (!out_valid_reg || pop);

    // slot table: one read when a job is taken, one write on insert
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            rd_data_reg <= slot_mem[rd_idx];
        end
        if ((state_reg == B_RESOLVE) && do_insert)
        begin
            slot_mem[cur_idx] <= {cur_reg.key, cur_reg.kind};
        end
    end

    // compare stored key and classify the outcome
    assign slot_used = used_reg[cur_idx];
    assign do_insert = cur_reg.key_valid && (cur_reg.action == ACT_INSERT);
    assign collide   = do_insert && slot_used;
    assign hit       = cur_reg.key_valid && (cur_reg.action == ACT_LOOKUP) && slot_used &&
                       (rd_data_reg[ENT_W-1:KIND_W] == cur_reg.key);

    always_comb
    begin
        count_next = count_reg;
        if (collide && (count_reg != {COUNT_W{1'b1}}))
        begin
            count_next = count_reg + 1'b1;
        end
        result_next.found           = hit;
        result_next.kind_out        = hit ? rd_data_reg[KIND_W-1:0] : '0;
        result_next.slot_index      = cur_reg.key_valid ? cur_reg.slot : '0;
        result_next.collided        = collide;
        result_next.collision_total = count_next;
    end

    // job sequencing, occupancy, counter and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            used_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (job_pop)
                    begin
                        cur_reg   <= job;
                        state_reg <= B_RESOLVE;
                    end
                end
                B_RESOLVE:
                begin
                    if (do_insert)
                    begin
                        used_reg[cur_idx] <= 1'b1;
                    end
                    count_reg     <= count_next;
                    result_reg    <= result_next;
                    out_valid_reg <= 1'b1;
                    state_reg     <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign empty  = !out_valid_reg;
    assign result = result_reg;

endmodule

### sv/keyword_hash_table.sv
`timescale 1ns / 1ps
// each word passes through the front, the queue and the back, which registers the result
// the front takes no new word until it has handed off the last; it takes the word, then does
//   the split 64-bit multiply, the product add, the shift, byte-serial modulo reduction and the
//   handoff, which waits while the queue is full; a word of invalid length goes to the handoff
// reset: asynchronous; all slots marked empty at once, collision count zero,
//   hash registers back to their defaults, queue empty

module keyword_hash_table #(
    parameter int TABLE_SIZE = khash_pkg::TABLE_SIZE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  khash_pkg::item_t                    item,
    output logic                                empty,
    input  logic                                pop,
    output khash_pkg::result_t                  result,
    input  logic                                cfg_wr_en,
    input  logic [khash_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [khash_pkg::KEY_W-1:0]         cfg_data
);
    import khash_pkg::*;

    cfg_t cfg_reg;
    job_t front_job;
    job_t back_job;
    logic front_push;
    logic queue_full;
    logic queue_empty;
    logic back_pop;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hash_multiplier <= HASH_MULTIPLIER_RST;
            cfg_reg.product_shift   <= PRODUCT_SHIFT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_HASH_MULTIPLIER: cfg_reg.hash_multiplier <= cfg_data;
                REG_PRODUCT_SHIFT:   cfg_reg.product_shift   <= cfg_data[SHIFT_W-1:0];
                default:             ;
            endcase
        end
    end

    // packing and hashing
    khash_front #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cfg      (cfg_reg),
        .job_push (front_push),
        .job_full (queue_full),
        .job      (front_job)
    );

    // decoupling queue
    khash_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (front_push),
        .full   (queue_full),
        .wr_job (front_job),
        .pop    (back_pop),
        .empty  (queue_empty),
        .rd_job (back_job)
    );

    // table access and result
    khash_back #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (queue_empty),
        .job_pop   (back_pop),
        .job       (back_job),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
